// File: rtl/tds_pkg.sv
// Package for the triangle depth sorter.
// Holds the default sizes, the cell operation codes and the controller states.
// Depends on nothing.
`default_nettype none

package tds_pkg;

  localparam int unsigned MaxTrianglesDef = 64;
  localparam int unsigned IndexBitsDef    = 16;
  localparam int unsigned DepthBitsDef    = 24;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DRAIN
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } sort_state_e;

endpackage

`default_nettype wire

// File: rtl/triangle_depth_sort.sv
// Each accepted triangle is placed into a chain of MAX_TRIANGLES sorting cells in the
// cycle it is accepted, unless the chain is full, so busy_o stays low and a triangle
// may be started every cycle while a mesh loads. The beat that carries mesh_last_i
// starts the output run: on the following cycles the chain shifts toward cell 0 and
// one sorted triangle appears per cycle, farthest first, marked by out_valid_o, until
// every stored triangle is out. busy_o is high during that run. The receiver cannot
// stall the run, so it must take a beat on every cycle in which out_valid_o is high.
// Depends on tds_pkg and tds_cell.
`default_nettype none

module triangle_depth_sort #(
  parameter int unsigned MAX_TRIANGLES = tds_pkg::MaxTrianglesDef,
  parameter int unsigned INDEX_BITS    = tds_pkg::IndexBitsDef,
  parameter int unsigned DEPTH_BITS    = tds_pkg::DepthBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [INDEX_BITS-1:0]            vert_a_i,
  input  wire logic [INDEX_BITS-1:0]            vert_b_i,
  input  wire logic [INDEX_BITS-1:0]            vert_c_i,
  input  wire logic signed [DEPTH_BITS-1:0]     depth_a_i,
  input  wire logic signed [DEPTH_BITS-1:0]     depth_b_i,
  input  wire logic signed [DEPTH_BITS-1:0]     depth_c_i,
  input  wire logic                             mesh_last_i,
  output logic                                  out_valid_o,
  output logic [INDEX_BITS-1:0]                 out_vert_a_o,
  output logic [INDEX_BITS-1:0]                 out_vert_b_o,
  output logic [INDEX_BITS-1:0]                 out_vert_c_o,
  output logic [$clog2(MAX_TRIANGLES)-1:0]      out_source_slot_o,
  output logic                                  out_overflow_o,
  output logic                                  out_last_o
);
  import tds_pkg::*;

  localparam int unsigned KEY_W  = DEPTH_BITS + 2;
  localparam int unsigned TRI_W  = 3 * INDEX_BITS;
  localparam int unsigned SLOT_W = $clog2(MAX_TRIANGLES);
  localparam int unsigned CNT_W  = $clog2(MAX_TRIANGLES + 1);

  sort_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              accept;
  logic              full;
  logic              run_end;
  cell_op_e          cell_op;

  logic [KEY_W-1:0]  new_key;
  logic [TRI_W-1:0]  new_tri;
  logic [SLOT_W-1:0] new_slot;

  logic              ge    [MAX_TRIANGLES];
  logic              valid [MAX_TRIANGLES];
  logic [KEY_W-1:0]  key   [MAX_TRIANGLES];
  logic [TRI_W-1:0]  tri_v [MAX_TRIANGLES];
  logic [SLOT_W-1:0] slot  [MAX_TRIANGLES];

  assign accept   = start_i && !busy_o;
  assign full     = (count_q == CNT_W'(MAX_TRIANGLES));
  assign new_key  = KEY_W'(depth_a_i) + KEY_W'(depth_b_i) + KEY_W'(depth_c_i);
  assign new_tri  = {vert_c_i, vert_b_i, vert_a_i};
  assign new_slot = count_q[SLOT_W-1:0];
  assign run_end  = !valid[1];

  for (genvar g = 0; g < MAX_TRIANGLES; g++) begin : g_cell
    logic              prev_ge, prev_valid, next_valid;
    logic [KEY_W-1:0]  prev_key, next_key;
    logic [TRI_W-1:0]  prev_tri, next_tri;
    logic [SLOT_W-1:0] prev_slot, next_slot;

    if (g == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_tri   = '0;
      assign prev_slot  = '0;
    end else begin : g_body
      assign prev_ge    = ge[g-1];
      assign prev_valid = valid[g-1];
      assign prev_key   = key[g-1];
      assign prev_tri   = tri_v[g-1];
      assign prev_slot  = slot[g-1];
    end

    if (g == MAX_TRIANGLES - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = '0;
      assign next_tri   = '0;
      assign next_slot  = '0;
    end else begin : g_inner
      assign next_valid = valid[g+1];
      assign next_key   = key[g+1];
      assign next_tri   = tri_v[g+1];
      assign next_slot  = slot[g+1];
    end

    tds_cell #(
      .KEY_W  (KEY_W),
      .IDX_W  (INDEX_BITS),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .new_key_i    (new_key),
      .new_tri_i    (new_tri),
      .new_slot_i   (new_slot),
      .prev_ge_i    (prev_ge),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_tri_i   (prev_tri),
      .prev_slot_i  (prev_slot),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .next_tri_i   (next_tri),
      .next_slot_i  (next_slot),
      .ge_o         (ge[g]),
      .valid_o      (valid[g]),
      .key_o        (key[g]),
      .tri_o        (tri_v[g]),
      .slot_o       (slot[g])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (mesh_last_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (run_end) begin
          state_d = ST_IDLE;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o      = 1'b0;
    out_valid_o = 1'b0;
    cell_op     = CELL_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (accept && !full) begin
          cell_op = CELL_INSERT;
        end
      end
      ST_DRAIN: begin
        busy_o      = 1'b1;
        out_valid_o = 1'b1;
        cell_op     = CELL_DRAIN;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_vert_a_o      = tri_v[0][INDEX_BITS-1:0];
  assign out_vert_b_o      = tri_v[0][2*INDEX_BITS-1:INDEX_BITS];
  assign out_vert_c_o      = tri_v[0][3*INDEX_BITS-1:2*INDEX_BITS];
  assign out_source_slot_o = slot[0];
  assign out_overflow_o    = ovf_q;
  assign out_last_o        = out_valid_o && run_end;

endmodule

`default_nettype wire

// File: rtl/tds_cell.sv
// One cell of the sorting chain: holds one triangle, its key and its load slot.
// Inserts in key order against its left neighbor and shifts left while draining.
// Depends on tds_pkg.
`default_nettype none

module tds_cell #(
  parameter int unsigned KEY_W  = 26,
  parameter int unsigned IDX_W  = 16,
  parameter int unsigned SLOT_W = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tds_pkg::cell_op_e    op_i,
  input  wire logic [KEY_W-1:0]     new_key_i,
  input  wire logic [3*IDX_W-1:0]   new_tri_i,
  input  wire logic [SLOT_W-1:0]    new_slot_i,
  input  wire logic                 prev_ge_i,
  input  wire logic                 prev_valid_i,
  input  wire logic [KEY_W-1:0]     prev_key_i,
  input  wire logic [3*IDX_W-1:0]   prev_tri_i,
  input  wire logic [SLOT_W-1:0]    prev_slot_i,
  input  wire logic                 next_valid_i,
  input  wire logic [KEY_W-1:0]     next_key_i,
  input  wire logic [3*IDX_W-1:0]   next_tri_i,
  input  wire logic [SLOT_W-1:0]    next_slot_i,
  output logic                      ge_o,
  output logic                      valid_o,
  output logic [KEY_W-1:0]          key_o,
  output logic [3*IDX_W-1:0]        tri_o,
  output logic [SLOT_W-1:0]         slot_o
);
  import tds_pkg::*;

  logic               valid_q, valid_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [3*IDX_W-1:0] tri_q, tri_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;

  // A cell keeps its entry when it holds a key at least as large as the new one.
  assign ge_o = valid_q && ($signed(key_q) >= $signed(new_key_i));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tri_d   = tri_q;
    slot_d  = slot_q;
    case (op_i)
      CELL_INSERT: begin
        if (!ge_o) begin
          if (prev_ge_i) begin
            valid_d = 1'b1;
            key_d   = new_key_i;
            tri_d   = new_tri_i;
            slot_d  = new_slot_i;
          end else begin
            valid_d = prev_valid_i;
            key_d   = prev_key_i;
            tri_d   = prev_tri_i;
            slot_d  = prev_slot_i;
          end
        end
      end
      CELL_DRAIN: begin
        valid_d = next_valid_i;
        key_d   = next_key_i;
        tri_d   = next_tri_i;
        slot_d  = next_slot_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    tri_q  <= tri_d;
    slot_q <= slot_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign tri_o   = tri_q;
  assign slot_o  = slot_q;

endmodule

`default_nettype wire

// File: rtl/tds_checker.sv
// Port-level checks for the triangle depth sorter and the bind that attaches them.
// Depends on triangle_depth_sort.
`default_nettype none

module tds_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic mesh_last_i,
  input wire logic out_valid_o,
  input wire logic out_last_o
);

  // No result beat appears while the block is free to take triangles.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o |-> !out_valid_o)
    else $error("result beat while not busy");

  // The final triangle of a mesh starts the output run on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mesh_last_i) |=> out_valid_o)
    else $error("output run did not start after the final triangle");

  // A run continues without gaps until its last beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |=> out_valid_o)
    else $error("output run ended without a last beat");

  // The block frees up right after the last beat of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |=> !busy_o)
    else $error("still busy after the last beat");

  // The last marker only rides on a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_last_o |-> out_valid_o)
    else $error("last marker without a result beat");

endmodule

bind triangle_depth_sort tds_checker u_tds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .mesh_last_i (mesh_last_i),
  .out_valid_o (out_valid_o),
  .out_last_o  (out_last_o)
);

`default_nettype wire
